FILE: src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// PAE page table walker package
// Shared payload types, walk levels, job codes and queue depths.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // Width of the physical address fields on the result side.
  localparam int unsigned PhysW = 52;

  // Depth of the job queue between front and back, and of the result queue.
  localparam int unsigned JobDepth = 2;
  localparam int unsigned ResDepth = 2;

  // Command codes of an input beat.
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // Kind codes of a result beat.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Walk level; the awaited level doubles as the fault code.
  typedef enum logic [1:0] {
    LVL_IDLE = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } walk_level_e;

  // Work the back end has to carry out for one classified beat.
  typedef enum logic [2:0] {
    JOB_ROOT  = 3'd0,
    JOB_NEXT  = 3'd1,
    JOB_FAULT = 3'd2,
    JOB_LARGE = 3'd3,
    JOB_PAGE  = 3'd4
  } job_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] virt_addr;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [PhysW-1:0] read_addr;
    logic [PhysW-1:0] phys_addr;
    logic [1:0]       fault_code;
    logic             large_page;
  } out_item_t;

  typedef struct packed {
    job_e        op;
    walk_level_e level;
    logic [31:0] vaddr;
    logic [63:0] entry;
    logic [26:0] base;
  } job_t;

endpackage

FILE: src/ptw_fifo.sv
// ----------------------------------------------------------------------------
// PAE page table walker queue
// Small register queue with full and empty flags, used between the stages.
// ----------------------------------------------------------------------------
module ptw_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t rdata_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  // Flags and handshake qualification.
  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and count updates.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, written in place without reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/ptw_front.sv
// ----------------------------------------------------------------------------
// PAE page table walker front end
// Accepts input beats, tracks the walk level and classifies each beat into
// a job for the back end.
// ----------------------------------------------------------------------------
module ptw_front
  import ptw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push_i,
  input  in_item_t    item_i,
  output logic        full_o,
  output logic        job_push_o,
  output job_t        job_o,
  input  logic        job_full_i
);

  walk_level_e level_q, level_d;
  logic [31:0] vaddr_q, vaddr_d;
  logic [31:0] base_q;
  logic        accept;

  // A beat is taken whenever the job queue has room.
  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  // Next walk state and the job for the accepted beat.
  always_comb begin
    level_d       = level_q;
    vaddr_d       = vaddr_q;
    job_push_o    = 1'b0;
    job_o.op      = JOB_ROOT;
    job_o.level   = level_q;
    job_o.vaddr   = vaddr_q;
    job_o.entry   = item_i.entry_data;
    job_o.base    = base_q[31:5];
    if (accept) begin
      if (item_i.cmd == CMD_TRANSLATE) begin
        // A new request always restarts the walk.
        level_d     = LVL_PDPT;
        vaddr_d     = item_i.virt_addr;
        job_o.vaddr = item_i.virt_addr;
        job_o.op    = JOB_ROOT;
        job_push_o  = 1'b1;
      end else if (level_q != LVL_IDLE) begin
        job_push_o = 1'b1;
        if (!item_i.entry_data[0]) begin
          job_o.op = JOB_FAULT;
          level_d  = LVL_IDLE;
        end else begin
          case (level_q)
            LVL_PDPT: begin
              job_o.op = JOB_NEXT;
              level_d  = LVL_PD;
            end
            LVL_PD: begin
              if (item_i.entry_data[7]) begin
                job_o.op = JOB_LARGE;
                level_d  = LVL_IDLE;
              end else begin
                job_o.op = JOB_NEXT;
                level_d  = LVL_PT;
              end
            end
            LVL_PT: begin
              job_o.op = JOB_PAGE;
              level_d  = LVL_IDLE;
            end
            default: begin
              job_push_o = 1'b0;
            end
          endcase
        end
      end
    end
  end

  // Walk state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_IDLE;
      vaddr_q <= '0;
    end else begin
      level_q <= level_d;
      vaddr_q <= vaddr_d;
    end
  end

  // Directory pointer table base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: src/ptw_back.sv
// ----------------------------------------------------------------------------
// PAE page table walker back end
// Turns a queued job into a result beat: entry read address, translated
// address or fault.
// ----------------------------------------------------------------------------
module ptw_back
  import ptw_pkg::*;
#(
  parameter int unsigned PHYS_BITS = 52
) (
  input  logic      job_empty_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam logic [PhysW:0]   MaskWide = (PhysW+1)'(1) << PHYS_BITS;
  localparam logic [PhysW:0]   MaskFull = MaskWide - (PhysW+1)'(1);
  localparam logic [PhysW-1:0] AddrMask = MaskFull[PhysW-1:0];

  logic [PhysW-1:0] base4k;
  logic [PhysW-1:0] base2m;
  logic [PhysW-1:0] root_addr;
  logic [8:0]       next_idx;

  // Move one job per cycle while the result queue has room.
  assign job_pop_o  = !job_empty_i && !res_full_i;
  assign res_push_o = job_pop_o;

  // Entry frame addresses, cut to the physical width.
  assign base4k    = {job_i.entry[PhysW-1:12], 12'b0} & AddrMask;
  assign base2m    = {job_i.entry[PhysW-1:21], 21'b0} & AddrMask;
  assign root_addr = {20'b0, job_i.base, 5'b0};
  assign next_idx  = (job_i.level == LVL_PDPT) ? job_i.vaddr[29:21] : job_i.vaddr[20:12];

  // Result for each job kind.
  always_comb begin
    res_o = '0;
    case (job_i.op)
      JOB_ROOT: begin
        res_o.kind      = KIND_READ;
        res_o.read_addr = (root_addr + {47'b0, job_i.vaddr[31:30], 3'b0}) & AddrMask;
      end
      JOB_NEXT: begin
        res_o.kind      = KIND_READ;
        res_o.read_addr = (base4k + {40'b0, next_idx, 3'b0}) & AddrMask;
      end
      JOB_FAULT: begin
        res_o.kind       = KIND_DONE;
        res_o.fault_code = job_i.level;
      end
      JOB_LARGE: begin
        res_o.kind       = KIND_DONE;
        res_o.phys_addr  = (base2m + {31'b0, job_i.vaddr[20:0]}) & AddrMask;
        res_o.large_page = 1'b1;
      end
      JOB_PAGE: begin
        res_o.kind      = KIND_DONE;
        res_o.phys_addr = (base4k + {40'b0, job_i.vaddr[11:0]}) & AddrMask;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

FILE: src/pae_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// PAE page table walker
// One beat in per cycle while the job queue has room; its job is registered in
// the job queue and its result in the result queue, from which it is popped.
// Throughput is one beat per cycle while both queues have room, set by the combinational job back end.
// Reset idles the walk, clears the held address, table base and both queues.
// ----------------------------------------------------------------------------
module pae_page_table_walker_unit
  import ptw_pkg::*;
#(
  parameter int unsigned PHYS_BITS = 52
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  input  in_item_t    in_item_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o
);

  logic      job_push, job_full, job_pop, job_empty;
  job_t      job_wdata, job_rdata;
  logic      res_push, res_full;
  out_item_t res_wdata;

  // Front end: classification and walk state.
  ptw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .job_push_o  (job_push),
    .job_o       (job_wdata),
    .job_full_i  (job_full)
  );

  // Job queue between front and back.
  ptw_fifo #(
    .item_t (job_t),
    .Depth  (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  // Back end: address arithmetic.
  ptw_back #(
    .PHYS_BITS (PHYS_BITS)
  ) u_back (
    .job_empty_i (job_empty),
    .job_i       (job_rdata),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata)
  );

  // Result queue toward the consumer.
  ptw_fifo #(
    .item_t (out_item_t),
    .Depth  (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule
